@@ sv/weighted_3x3_pixel_average_macros.svh @@
// Assertion helpers for the weighted 3x3 average block.
// Clock and reset names are fixed to clk_i / rst_ni.
`ifndef WEIGHTED_3X3_PIXEL_AVERAGE_MACROS_SVH
`define WEIGHTED_3X3_PIXEL_AVERAGE_MACROS_SVH

// Same-cycle implication.
`define WPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wpa assertion failed");

// Next-cycle implication.
`define WPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wpa assertion failed");

`endif

@@ sv/wpa_pkg.sv @@
package wpa_pkg;

  localparam int COORD_W     = 12;
  localparam int DIM_W       = 13;
  localparam int PIX_W       = 32;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 4;
  localparam int NUM_TAPS    = 9;
  localparam int KW_W        = 7;
  localparam int WSUM_W      = 8;
  localparam int ACC_W       = 16;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = ACC_W + RECIP_W;
  localparam int CFG_IDX_W   = 1;

  localparam int unsigned MAX_DIM_DEF = 4096;
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // row-major kernel
  localparam logic [KW_W-1:0] KERN_WEIGHT [NUM_TAPS] = '{
    7'd10, 7'd20, 7'd10,
    7'd20, 7'd80, 7'd20,
    7'd10, 7'd20, 7'd10
  };

  typedef struct packed {
    logic [2:0] rows;
    logic [2:0] cols;
  } tap_mask_t;

  function automatic logic [NUM_TAPS-1:0] tap_enables(tap_mask_t m);
    logic [NUM_TAPS-1:0] en;
    en = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        en[r*3+c] = m.rows[r] & m.cols[c];
      end
    end
    return en;
  endfunction

  function automatic logic [WSUM_W-1:0] wsum_of(logic [NUM_TAPS-1:0] en);
    logic [WSUM_W-1:0] s;
    s = '0;
    for (int t = 0; t < NUM_TAPS; t++) begin
      if (en[t]) begin
        s = s + WSUM_W'(KERN_WEIGHT[t]);
      end
    end
    return s;
  endfunction

  // ceil(2^24 / d); exact floor division for every numerator below 2^16
  function automatic logic [RECIP_W-1:0] recip_of(logic [WSUM_W-1:0] d);
    logic [RECIP_W-1:0] m;
    unique case (d)
      8'd10:   m = 21'd1677722;
      8'd20:   m = 21'd838861;
      8'd30:   m = 21'd559241;
      8'd40:   m = 21'd419431;
      8'd80:   m = 21'd209716;
      8'd100:  m = 21'd167773;
      8'd120:  m = 21'd139811;
      8'd130:  m = 21'd129056;
      8'd160:  m = 21'd104858;
      8'd200:  m = 21'd83887;
      default: m = '0;  // no tap inside
    endcase
    return m;
  endfunction

endpackage

@@ sv/weighted_3x3_pixel_average.sv @@
// Weighted 3x3 average with edge normalization, four channel lanes in parallel.
// Registered stages from input accept to result valid: tap mask, weighted sum, divide.
// Throughput: 1 item per cycle; the three-register pipeline stalls as one on output back-pressure.
// Reset (rst_ni low, async): pipeline empties, width and height return to 4096.
`include "weighted_3x3_pixel_average_macros.svh"

module weighted_3x3_pixel_average #(
  parameter int unsigned MAX_DIM = wpa_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [wpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wpa_pkg::DIM_W-1:0]      cfg_wdata_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wpa_pkg::COORD_W-1:0]    center_x_i,
  input  logic [wpa_pkg::COORD_W-1:0]    center_y_i,
  input  logic [wpa_pkg::PIX_W-1:0]      pix_up_left_i,
  input  logic [wpa_pkg::PIX_W-1:0]      pix_up_mid_i,
  input  logic [wpa_pkg::PIX_W-1:0]      pix_up_right_i,
  input  logic [wpa_pkg::PIX_W-1:0]      pix_mid_left_i,
  input  logic [wpa_pkg::PIX_W-1:0]      pix_center_i,
  input  logic [wpa_pkg::PIX_W-1:0]      pix_mid_right_i,
  input  logic [wpa_pkg::PIX_W-1:0]      pix_down_left_i,
  input  logic [wpa_pkg::PIX_W-1:0]      pix_down_mid_i,
  input  logic [wpa_pkg::PIX_W-1:0]      pix_down_right_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wpa_pkg::PIX_W-1:0]      filtered_color_o
);
  import wpa_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipe is idle; the block does not enforce this.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one enable for all stages, so an item enters every cycle
  // unless the result register is full and not being taken.
  // ---------------------------------------------------------------------------
  logic       pipe_en;
  logic [2:0] vld_q;   // [0] mask stage, [1] sum stage, [2] result register

  assign pipe_en     = !vld_q[2] || out_ready_i;
  assign in_ready_o  = pipe_en;
  assign out_valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[1:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: which taps lie inside the image, plus the pixels themselves.
  // ---------------------------------------------------------------------------
  tap_mask_t            mask;
  logic [PIX_W-1:0]     pix_in [NUM_TAPS];
  logic [PIX_W-1:0]     pix_q  [NUM_TAPS];
  logic [NUM_TAPS-1:0]  tap_en_q;

  assign pix_in[0] = pix_up_left_i;
  assign pix_in[1] = pix_up_mid_i;
  assign pix_in[2] = pix_up_right_i;
  assign pix_in[3] = pix_mid_left_i;
  assign pix_in[4] = pix_center_i;
  assign pix_in[5] = pix_mid_right_i;
  assign pix_in[6] = pix_down_left_i;
  assign pix_in[7] = pix_down_mid_i;
  assign pix_in[8] = pix_down_right_i;

  wpa_tap_mask #(
    .MAX_DIM(MAX_DIM)
  ) u_tap_mask (
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .image_width_i (width_q),
    .image_height_i(height_q),
    .mask_o        (mask)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      tap_en_q <= tap_enables(mask);
      pix_q    <= pix_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: divisor reciprocal, shared by all lanes. Zero when no tap is
  // inside, which forces a zero result without a separate path.
  // ---------------------------------------------------------------------------
  logic [RECIP_W-1:0] recip_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      recip_q <= recip_of(wsum_of(tap_en_q));
    end
  end

  // ---------------------------------------------------------------------------
  // Channel lanes: each sums its byte over the taps (stage 2) and divides
  // (stage 3). The result register packs the four lane outputs.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0] lane_taps [NUM_CH][NUM_TAPS];
  logic [CH_W-1:0] lane_out  [NUM_CH];

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
      assign lane_taps[ch][t] = pix_q[t][ch*CH_W +: CH_W];
    end

    wpa_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .taps_i  (lane_taps[ch]),
      .tap_en_i(tap_en_q),
      .recip_i (recip_q),
      .chan_o  (lane_out[ch])
    );

    assign filtered_color_o[ch*CH_W +: CH_W] = lane_out[ch];
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `WPA_ASSERT_NEXT(a_accept_enters_pipe, in_valid_i && in_ready_o, vld_q[0])
  `WPA_ASSERT_NEXT(a_stall_holds_pipe, !pipe_en, $stable(vld_q))
  `WPA_ASSERT_NEXT(a_inside_gives_divisor, vld_q[0] && pipe_en && (tap_en_q != '0),
                   recip_q != '0)
  `WPA_ASSERT_NEXT(a_no_tap_gives_zero, vld_q[1] && pipe_en && (recip_q == '0),
                   filtered_color_o == '0)

endmodule

@@ sv/wpa_tap_mask.sv @@
module wpa_tap_mask #(
  parameter int unsigned MAX_DIM = wpa_pkg::MAX_DIM_DEF
) (
  input  logic [wpa_pkg::COORD_W-1:0] center_x_i,
  input  logic [wpa_pkg::COORD_W-1:0] center_y_i,
  input  logic [wpa_pkg::DIM_W-1:0]   image_width_i,
  input  logic [wpa_pkg::DIM_W-1:0]   image_height_i,
  output wpa_pkg::tap_mask_t          mask_o
);
  import wpa_pkg::*;

  localparam int unsigned DimMax = (1 << DIM_W) - 1;
  localparam int unsigned DimCap = (MAX_DIM > DimMax) ? DimMax : MAX_DIM;
  localparam int CMP_W = DIM_W + 1;

  logic [DIM_W-1:0] w_clamp, h_clamp;

  assign w_clamp = (32'(image_width_i) > 32'(MAX_DIM)) ? DIM_W'(DimCap) : image_width_i;
  assign h_clamp = (32'(image_height_i) > 32'(MAX_DIM)) ? DIM_W'(DimCap) : image_height_i;

  function automatic logic [2:0] span(logic [COORD_W-1:0] c, logic [DIM_W-1:0] lim);
    logic [CMP_W-1:0] ce, le;
    logic [2:0] s;
    ce = CMP_W'(c);
    le = CMP_W'(lim);
    // offset -1 is out when the centre sits on coordinate zero
    s[0] = (c != '0) && ((ce - CMP_W'(1)) < le);
    s[1] = ce < le;
    s[2] = (ce + CMP_W'(1)) < le;
    return s;
  endfunction

  assign mask_o.cols = span(center_x_i, w_clamp);
  assign mask_o.rows = span(center_y_i, h_clamp);

endmodule

@@ sv/wpa_lane.sv @@
module wpa_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [wpa_pkg::CH_W-1:0]      taps_i [wpa_pkg::NUM_TAPS],
  input  logic [wpa_pkg::NUM_TAPS-1:0]  tap_en_i,
  input  logic [wpa_pkg::RECIP_W-1:0]   recip_i,
  output logic [wpa_pkg::CH_W-1:0]      chan_o
);
  import wpa_pkg::*;

  logic [ACC_W-1:0]  acc_d, acc_q;
  logic [PROD_W-1:0] prod;
  logic [CH_W-1:0]   chan_d, chan_q;

  // weighted sum of the inside taps
  always_comb begin
    acc_d = '0;
    for (int t = 0; t < NUM_TAPS; t++) begin
      if (tap_en_i[t]) begin
        acc_d = acc_d + ACC_W'(taps_i[t]) * ACC_W'(KERN_WEIGHT[t]);
      end
    end
  end

  // floor division by reciprocal multiply; quotient never exceeds 255
  assign prod   = PROD_W'(acc_q) * PROD_W'(recip_i);
  assign chan_d = prod[RECIP_SHIFT +: CH_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q  <= acc_d;
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

@@ verif/weighted_3x3_pixel_average_tb.sv @@
// Self-checking bench for the weighted 3x3 average filter.
// A directed table runs first and covers corners, edges, zero and oversized
// dimensions, and windows whose centre lies off the image. Random windows
// follow in phases, one image size per phase. Every accepted item queues an
// expected result. Each result is checked against the oldest expected one.
module weighted_3x3_pixel_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpa_pkg::*;

  // One directed row: the image size to run it under, the window and, where
  // the answer is obvious, the result typed in. taps[0] is the upper-left
  // tap, taps[8] the lower-right tap (row-major, same as the ports).
  typedef struct packed {
    logic [DIM_W-1:0]            img_w;
    logic [DIM_W-1:0]            img_h;
    logic [COORD_W-1:0]          cx;
    logic [COORD_W-1:0]          cy;
    logic [0:8][PIX_W-1:0]       taps;
    logic                        known;
    logic [PIX_W-1:0]            color;
  } window_row_t;

  localparam logic [0:8][PIX_W-1:0] ALL_ONES = {9{32'hFFFF_FFFF}};
  localparam logic [0:8][PIX_W-1:0] ALL_ZERO = {9{32'h0000_0000}};
  localparam logic [0:8][PIX_W-1:0] MIXED_TAPS = {
    32'h0102_0304, 32'h1020_3040, 32'h80FF_7F00,
    32'hFFFF_FFFF, 32'h0000_0000, 32'hDEAD_BEEF,
    32'h5A5A_5A5A, 32'hA5C3_E1F0, 32'h0F1E_2D3C
  };
  localparam logic [0:8][PIX_W-1:0] STRIPE_TAPS = {
    32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
    32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA
  };
  localparam logic [0:8][PIX_W-1:0] CENTER_ONLY = {
    32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0
  };
  localparam logic [0:8][PIX_W-1:0] CENTER_TAGGED = {
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };
  localparam logic [0:8][PIX_W-1:0] CORNER_TAGGED = {
    32'hCAFE_F00D, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };

  localparam int NUM_DIRECTED = 21;
  localparam window_row_t DIRECTED [NUM_DIRECTED] = '{
    // top-left corner of a full-size image: four taps inside
    '{13'd4096, 13'd4096, 12'd0,    12'd0,    ALL_ONES,      1'b1, 32'hFFFF_FFFF},
    // bottom-right corner, all black
    '{13'd4096, 13'd4096, 12'd4095, 12'd4095, ALL_ZERO,      1'b1, 32'h0000_0000},
    '{13'd4096, 13'd4096, 12'd4095, 12'd0,    MIXED_TAPS,    1'b0, 32'h0},
    '{13'd4096, 13'd4096, 12'd0,    12'd4095, MIXED_TAPS,    1'b0, 32'h0},
    '{13'd4096, 13'd4096, 12'd2048, 12'd1024, ALL_ONES,      1'b1, 32'hFFFF_FFFF},
    '{13'd4096, 13'd4096, 12'd100,  12'd200,  CENTER_ONLY,   1'b0, 32'h0},
    '{13'd4096, 13'd4096, 12'd100,  12'd200,  MIXED_TAPS,    1'b0, 32'h0},
    // zero width, then zero height: nothing inside
    '{13'd0,    13'd4096, 12'd5,    12'd5,    ALL_ONES,      1'b1, 32'h0000_0000},
    '{13'd4096, 13'd0,    12'd5,    12'd5,    ALL_ONES,      1'b1, 32'h0000_0000},
    // 1x1 image: only the centre tap counts
    '{13'd1,    13'd1,    12'd0,    12'd0,    CENTER_TAGGED, 1'b1, 32'h1234_5678},
    // centre off the image, but the upper-left tap still lands on it
    '{13'd1,    13'd1,    12'd1,    12'd1,    CORNER_TAGGED, 1'b1, 32'hCAFE_F00D},
    // centre off the image, no tap inside
    '{13'd1,    13'd1,    12'd2,    12'd0,    ALL_ONES,      1'b1, 32'h0000_0000},
    '{13'd1,    13'd1,    12'd4095, 12'd4095, ALL_ONES,      1'b1, 32'h0000_0000},
    // oversized dimensions saturate to the maximum; then a 2x2 image
    '{13'd8191, 13'd8191, 12'd4095, 12'd4095, MIXED_TAPS,    1'b0, 32'h0},
    '{13'd4097, 13'd4097, 12'd4095, 12'd4095, MIXED_TAPS,    1'b0, 32'h0},
    '{13'd4097, 13'd4097, 12'd4095, 12'd2000, STRIPE_TAPS,   1'b0, 32'h0},
    '{13'd2,    13'd2,    12'd1,    12'd1,    MIXED_TAPS,    1'b0, 32'h0},
    // 3x3 image, window fully inside; then a full-size bottom-right corner
    '{13'd3,    13'd3,    12'd1,    12'd1,    ALL_ONES,      1'b1, 32'hFFFF_FFFF},
    '{13'd3,    13'd3,    12'd1,    12'd1,    ALL_ZERO,      1'b1, 32'h0000_0000},
    '{13'd3,    13'd3,    12'd1,    12'd1,    MIXED_TAPS,    1'b0, 32'h0},
    '{13'd4096, 13'd4096, 12'd4095, 12'd4095, STRIPE_TAPS,   1'b0, 32'h0}
  };

  localparam int unsigned TAP_WEIGHT [9] = '{10, 20, 10, 20, 80, 20, 10, 20, 10};

  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int BLANK_ITEMS = 40;   // phases with a zero dimension
  localparam int PIPE_PAD    = 6;    // slack after the last result arrives
  localparam int HOLD_AT     = 500;  // item count that triggers the long stall
  localparam int HOLD_CYCLES = 64;

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i      = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0]       cfg_wdata_i      = '0;
  logic                   in_valid_i       = 1'b0;
  logic                   in_ready_o;
  logic [COORD_W-1:0]     center_x_i       = '0;
  logic [COORD_W-1:0]     center_y_i       = '0;
  logic [PIX_W-1:0]       pix_up_left_i    = '0;
  logic [PIX_W-1:0]       pix_up_mid_i     = '0;
  logic [PIX_W-1:0]       pix_up_right_i   = '0;
  logic [PIX_W-1:0]       pix_mid_left_i   = '0;
  logic [PIX_W-1:0]       pix_center_i     = '0;
  logic [PIX_W-1:0]       pix_mid_right_i  = '0;
  logic [PIX_W-1:0]       pix_down_left_i  = '0;
  logic [PIX_W-1:0]       pix_down_mid_i   = '0;
  logic [PIX_W-1:0]       pix_down_right_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i      = 1'b0;
  logic [PIX_W-1:0]       filtered_color_o;

  // Shadow copy of the size registers, as last written.
  logic [DIM_W-1:0]       img_w = DIM_RESET;
  logic [DIM_W-1:0]       img_h = DIM_RESET;

  logic [PIX_W-1:0]       pending_colors [$];
  int                     windows_sent = 0;
  int                     fails        = 0;
  bit                     quiet        = 1'b0;  // no idling on either side

  weighted_3x3_pixel_average u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .center_x_i       (center_x_i),
    .center_y_i       (center_y_i),
    .pix_up_left_i    (pix_up_left_i),
    .pix_up_mid_i     (pix_up_mid_i),
    .pix_up_right_i   (pix_up_right_i),
    .pix_mid_left_i   (pix_mid_left_i),
    .pix_center_i     (pix_center_i),
    .pix_mid_right_i  (pix_mid_right_i),
    .pix_down_left_i  (pix_down_left_i),
    .pix_down_mid_i   (pix_down_mid_i),
    .pix_down_right_i (pix_down_right_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_color_o (filtered_color_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sizes above the maximum behave as the maximum.
  function automatic int eff_dim(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM_DEF) ? int'(MAX_DIM_DEF) : int'(d);
  endfunction

  // Weighted average over the taps that land on the image, floored per
  // channel; black when no tap lands.
  function automatic logic [PIX_W-1:0] filter_window(input logic [COORD_W-1:0] cx,
                                                     input logic [COORD_W-1:0] cy,
                                                     input logic [0:8][PIX_W-1:0] taps);
    int unsigned acc [NUM_CH];
    int unsigned wsum;
    int          sx;
    int          sy;
    logic [PIX_W-1:0] color;
    acc   = '{default: 0};
    wsum  = 0;
    color = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sy = int'(cy) + r - 1;
        sx = int'(cx) + c - 1;
        if (sy >= 0 && sy < eff_dim(img_h) && sx >= 0 && sx < eff_dim(img_w)) begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            acc[ch] += int'(taps[r*3+c][CH_W*ch +: CH_W]) * TAP_WEIGHT[r*3+c];
          end
          wsum += TAP_WEIGHT[r*3+c];
        end
      end
    end
    if (wsum != 0) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        color[CH_W*ch +: CH_W] = CH_W'(acc[ch] / wsum);
      end
    end
    return color;
  endfunction

  // Coordinates cluster around the image borders and the top of the range,
  // where the tap masks change.
  function automatic logic [COORD_W-1:0] pick_coord(input int span);
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 4095);
      1: v = $urandom_range(0, 2);
      2: v = span - 2 + int'($urandom_range(0, 3));
      3: v = $urandom_range(4093, 4095);
      default: v = (span > 0) ? int'($urandom_range(0, span - 1)) : int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return COORD_W'(v);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    logic [PIX_W-1:0] p;
    case ($urandom_range(0, 5))
      0: p = '0;
      1: p = '1;
      2: begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          case ($urandom_range(0, 2))
            0: p[CH_W*ch +: CH_W] = 8'h00;
            1: p[CH_W*ch +: CH_W] = 8'hFF;
            default: p[CH_W*ch +: CH_W] = CH_W'($urandom());
          endcase
        end
      end
      default: p = $urandom();
    endcase
    return p;
  endfunction

  // Offers one window and waits for it to be taken. The expected color is
  // the typed one when given, else the predicted one.
  task automatic send_window(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input logic [0:8][PIX_W-1:0] taps,
                             input logic known, input logic [PIX_W-1:0] color);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    center_x_i       <= cx;
    center_y_i       <= cy;
    pix_up_left_i    <= taps[0];
    pix_up_mid_i     <= taps[1];
    pix_up_right_i   <= taps[2];
    pix_mid_left_i   <= taps[3];
    pix_center_i     <= taps[4];
    pix_mid_right_i  <= taps[5];
    pix_down_left_i  <= taps[6];
    pix_down_mid_i   <= taps[7];
    pix_down_right_i <= taps[8];
    do @(posedge clk_i); while (!in_ready_o);
    pending_colors.push_back(known ? color : filter_window(cx, cy, taps));
    windows_sent++;
  endtask

  // Stop offering and let the pipeline empty out.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (PIPE_PAD) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_w = data;
    else img_h = data;
  endtask

  task automatic load_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Receiver: short random stalls, plus one long hold-off so the pipeline
  // fills and pushes back on the sender.
  initial begin : rx_ready
    bit held;
    int stall;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && windows_sent >= HOLD_AT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 4);
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker: every accepted color against the oldest prediction.
  always @(posedge clk_i) begin
    logic [PIX_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colors.size() == 0) begin
        fails++;
        $display("%0t: filtered_color %08h arrived, expected none", $time,
                 filtered_color_o);
      end else begin
        want = pending_colors.pop_front();
        if (filtered_color_o !== want) begin
          fails++;
          $display("%0t: filtered_color expected %08h actual %08h", $time, want,
                   filtered_color_o);
        end
      end
    end
  end

  initial begin : stimulus
    logic [DIM_W-1:0]      w;
    logic [DIM_W-1:0]      h;
    logic [0:8][PIX_W-1:0] taps;
    int                    count;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; the size registers change only between rows that ask
    // for a new size.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].img_w != img_w || DIRECTED[i].img_h != img_h) begin
        load_dims(DIRECTED[i].img_w, DIRECTED[i].img_h);
      end
      send_window(DIRECTED[i].cx, DIRECTED[i].cy, DIRECTED[i].taps,
                  DIRECTED[i].known, DIRECTED[i].color);
    end

    // Random phases, one image size each; the last runs with no idling.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      count = PHASE_ITEMS;
      case (ph)
        0: begin w = 13'd4096; h = 13'd4096; end
        1: begin w = 13'd1;    h = 13'd1;    end
        2: begin w = 13'd2;    h = 13'd3;    end
        3: begin w = 13'd8191; h = 13'd8191; end
        4: begin w = 13'd0;    h = 13'd17;   count = BLANK_ITEMS; end
        5: begin w = 13'd9;    h = 13'd0;    count = BLANK_ITEMS; end
        6: begin
          w = DIM_W'($urandom_range(1, 16));
          h = DIM_W'($urandom_range(1, 16));
        end
        7: begin
          w = DIM_W'($urandom());
          h = DIM_W'($urandom());
        end
        8: begin
          w = DIM_W'($urandom_range(1, 64));
          h = DIM_W'($urandom_range(1, 64));
        end
        default: begin
          w = DIM_W'($urandom_range(1, 4096));
          h = DIM_W'($urandom_range(1, 4096));
        end
      endcase
      load_dims(w, h);
      quiet = (ph == NUM_PHASES - 1);
      for (int k = 0; k < count; k++) begin
        for (int t = 0; t < NUM_TAPS; t++) taps[t] = pick_pixel();
        send_window(pick_coord(eff_dim(w)), pick_coord(eff_dim(h)), taps, 1'b0, '0);
      end
    end

    drain();
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/wpa_pkg.sv
sv/wpa_tap_mask.sv
sv/wpa_lane.sv
sv/weighted_3x3_pixel_average.sv
verif/weighted_3x3_pixel_average_tb.sv
